// File: hdl/delay_jitter_packet_queue_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet delay/jitter queue
// Shared property forms used by the top level checks.
// ---------------------------------------------------------------------------
`ifndef DELAY_JITTER_PACKET_QUEUE_TOP_DEFINES_SVH
`define DELAY_JITTER_PACKET_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DJPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DJPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/djpq_pkg.sv
// ---------------------------------------------------------------------------
// djpq_pkg
// Types and constants shared by the delay/jitter queue controller and datapath.
// ---------------------------------------------------------------------------
package djpq_pkg;

  // Port field widths
  localparam int NOW_W      = 32;
  localparam int HANDLE_W   = 16;
  localparam int LENGTH_W   = 16;
  localparam int DESC_W     = HANDLE_W + LENGTH_W + 1;
  localparam int FLUSH_W    = 5;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_W      = 20;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DELAY  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_JITTER = 1'd1;

  // Random generator
  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_INC  = 32'd1013904223;
  localparam logic [31:0] RNG_SEED = 32'h0000_5EED;

  // Offset arithmetic: signed count of 2^-25 ticks
  localparam int FRAC_W     = 26;
  localparam int NUM_W      = 47;
  localparam int HALF_SHIFT = 25;
  localparam int OFF_W      = NUM_W - HALF_SHIFT;
  localparam logic signed [FRAC_W-1:0] FRAC_ONE = 26'sd16777216;
  localparam logic signed [NUM_W-1:0]  CEIL_ADD = 47'sd33554431;

  // Deliveries per tick
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_QUEUED    = 3'd0,
    STAT_PASSED    = 3'd1,
    STAT_DROPPED   = 3'd2,
    STAT_DELIVERED = 3'd3,
    STAT_NONE_DUE  = 3'd4,
    STAT_FLUSHED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_MUL,
    S_OFF,
    S_REL,
    S_TREAD,
    S_TCHK,
    S_CLOSE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    lcg_step;
    logic    mul_step;
    logic    off_step;
    logic    rel_step;
    logic    tick_start;
    logic    pend_load;
    logic    head_adv;
    logic    flush;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bypass;
    logic full;
    logic due;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/djpq_ram.sv
// ---------------------------------------------------------------------------
// djpq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module djpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/djpq_ctrl.sv
// ---------------------------------------------------------------------------
// djpq_ctrl
// Sequencer for send, tick and close requests of the delay/jitter queue.
// ---------------------------------------------------------------------------
module djpq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [djpq_pkg::CMD_W-1:0]      in_cmd,
  output logic                            in_ready,
  input  djpq_pkg::dp_stat_t              st,
  output djpq_pkg::ctl_cmd_t              cmd
);

  import djpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_SEND:  state_nxt = S_SEND;
            CMD_TICK:  state_nxt = S_TREAD;
            CMD_CLOSE: state_nxt = S_CLOSE;
            default:   state_nxt = S_IDLE;   // unused code, dropped
          endcase
        end
      end
      S_SEND: begin
        if (st.bypass || st.full) begin
          if (st.out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_OFF;
      S_OFF:   state_nxt = S_REL;
      S_REL:   if (st.out_free) state_nxt = S_IDLE;
      S_TREAD: state_nxt = S_TCHK;
      S_TCHK: begin
        if (st.due) begin
          if (!st.pend_valid || st.out_free) state_nxt = S_TREAD;
        end else if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLOSE: if (st.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.emit_status = STAT_QUEUED;
    unique case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_in    = in_valid;
        cmd.tick_start = in_valid && (cmd_t'(in_cmd) == CMD_TICK);
      end
      S_SEND: begin
        if (st.bypass) begin
          cmd.emit        = st.out_free;
          cmd.emit_status = STAT_PASSED;
          cmd.emit_last   = 1'b1;
        end else if (st.full) begin
          cmd.emit        = st.out_free;
          cmd.emit_status = STAT_DROPPED;
          cmd.emit_last   = 1'b1;
        end else begin
          cmd.lcg_step = 1'b1;
        end
      end
      S_MUL: cmd.mul_step = 1'b1;
      S_OFF: cmd.off_step = 1'b1;
      S_REL: begin
        cmd.rel_step    = st.out_free;
        cmd.emit        = st.out_free;
        cmd.emit_status = STAT_QUEUED;
        cmd.emit_last   = 1'b1;
      end
      S_TREAD: ;
      S_TCHK: begin
        if (st.due) begin
          // hold the entry back until we know whether another follows
          if (!st.pend_valid || st.out_free) begin
            cmd.pend_load   = 1'b1;
            cmd.head_adv    = 1'b1;
            cmd.emit        = st.pend_valid;
            cmd.emit_status = STAT_DELIVERED;
          end
        end else begin
          cmd.emit        = st.out_free;
          cmd.emit_status = st.pend_valid ? STAT_DELIVERED : STAT_NONE_DUE;
          cmd.emit_last   = 1'b1;
        end
      end
      S_CLOSE: begin
        cmd.flush       = st.out_free;
        cmd.emit        = st.out_free;
        cmd.emit_status = STAT_FLUSHED;
        cmd.emit_last   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/djpq_datapath.sv
// ---------------------------------------------------------------------------
// djpq_datapath
// Queue storage, random generator, release time arithmetic and result register.
// ---------------------------------------------------------------------------
module djpq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [djpq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [djpq_pkg::CFG_W-1:0]           cfg_wdata,
  // request payload
  input  logic [djpq_pkg::IN_DATA_W-1:0]       in_tdata,
  // result
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [djpq_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [djpq_pkg::STATUS_W-1:0]        out_tuser,
  output logic                                 out_tlast,
  // control
  input  djpq_pkg::ctl_cmd_t                   cmd,
  output djpq_pkg::dp_stat_t                   st
);

  import djpq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int AT_W  = ((TIME_BITS > OFF_W) ? TIME_BITS : OFF_W) + 2;
  localparam logic [IDX_W-1:0]     IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};

  // Configuration registers
  logic [CFG_W-1:0] delay_r, jitter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= '0;
      jitter_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_DELAY:  delay_r  <= cfg_wdata;
        CFG_IDX_JITTER: jitter_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched request
  logic [TIME_BITS-1:0] now_r;
  logic [DESC_W-1:0]    desc_in_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r     <= TIME_BITS'(in_tdata[NOW_W-1:0]);
      desc_in_r <= in_tdata[NOW_W +: DESC_W];
    end
  end

  // Queue pointers and occupancy
  logic [IDX_W-1:0]     head_r, tail_r;
  logic [CNT_W-1:0]     count_r;
  logic [TIME_BITS-1:0] last_rel_r;
  logic [TIME_BITS-1:0] rel_nxt;
  logic [TIME_BITS-1:0] rel_rd;
  logic [DESC_W-1:0]    desc_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      last_rel_r <= '0;
    end else if (cmd.flush) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      last_rel_r <= '0;
    end else if (cmd.rel_step) begin
      tail_r     <= (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
      count_r    <= count_r + 1'b1;
      last_rel_r <= rel_nxt;
    end else if (cmd.head_adv) begin
      head_r  <= (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
      count_r <= count_r - 1'b1;
    end
  end

  djpq_ram #(.WIDTH(TIME_BITS), .DEPTH(QUEUE_DEPTH)) u_rel_ram (
    .clk     (clk),
    .wr_en   (cmd.rel_step),
    .wr_addr (tail_r),
    .wr_data (rel_nxt),
    .rd_addr (head_r),
    .rd_data (rel_rd)
  );

  djpq_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_desc_ram (
    .clk     (clk),
    .wr_en   (cmd.rel_step),
    .wr_addr (tail_r),
    .wr_data (desc_in_r),
    .rd_addr (head_r),
    .rd_data (desc_rd)
  );

  // LCG step
  logic [31:0] rng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= RNG_SEED;
    end else if (cmd.lcg_step) begin
      rng_r <= rng_r * LCG_MUL + LCG_INC;
    end
  end

  // Jitter term: (2u - 2^24) * jitter
  logic signed [FRAC_W-1:0] frac;
  logic signed [CFG_W:0]    jit_s;
  logic signed [NUM_W-1:0]  prod_r;

  assign frac  = $signed({1'b0, rng_r[31:8], 1'b0}) - FRAC_ONE;
  assign jit_s = $signed({1'b0, jitter_r});

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      prod_r <= NUM_W'(frac) * NUM_W'(jit_s);
    end
  end

  // Offset in whole ticks, rounded up
  logic signed [NUM_W-1:0] num_rnd;
  logic signed [OFF_W-1:0] off_r;

  assign num_rnd = $signed({3'b000, delay_r, 24'd0}) + prod_r + CEIL_ADD;

  always_ff @(posedge clk) begin
    if (cmd.off_step) begin
      off_r <= num_rnd[NUM_W-1:HALF_SHIFT];
    end
  end

  // Release time: clamp to previous release, saturate to the time range
  logic signed [AT_W-1:0] now_ext, off_ext, at_s;
  logic        [AT_W-1:0] at_u;

  assign now_ext = AT_W'(now_r);
  assign off_ext = AT_W'(off_r);
  assign at_s    = now_ext + off_ext;
  assign at_u    = at_s;

  always_comb begin
    if (at_s[AT_W-1] || (at_u < AT_W'(last_rel_r))) begin
      rel_nxt = last_rel_r;
    end else if (at_u > AT_W'(TIME_MASK)) begin
      rel_nxt = TIME_MASK;
    end else begin
      rel_nxt = at_u[TIME_BITS-1:0];
    end
  end

  // Delivery held back for one step of the tick walk
  logic [DESC_W-1:0]    pend_r;
  logic                 pend_valid_r;
  logic [RES_CNT_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      n_r          <= '0;
    end else if (cmd.tick_start) begin
      pend_valid_r <= 1'b0;
      n_r          <= '0;
    end else if (cmd.pend_load) begin
      pend_valid_r <= 1'b1;
      n_r          <= n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_r <= desc_rd;
    end
  end

  // Result register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [DESC_W-1:0]    out_desc_r;
  logic [FLUSH_W-1:0]   out_flush_r;
  logic                 out_last_r;
  logic [DESC_W-1:0]    emit_desc;

  always_comb begin
    case (cmd.emit_status)
      STAT_PASSED:    emit_desc = desc_in_r;
      STAT_DELIVERED: emit_desc = pend_r;
      default:        emit_desc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_desc_r   <= emit_desc;
      out_flush_r  <= (cmd.emit_status == STAT_FLUSHED) ? FLUSH_W'(count_r) : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - DESC_W - FLUSH_W){1'b0}}, out_flush_r, out_desc_r};

  // Status to the controller
  assign st.bypass     = (delay_r == '0) && (jitter_r == '0) && (count_r == '0);
  assign st.full       = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign st.due        = (count_r != '0) && (rel_rd <= now_r)
                         && (n_r < RES_CNT_W'(MAX_RESULTS));
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = !out_valid_r || out_tready;

endmodule

// File: hdl/delay_jitter_packet_queue_top.sv
// ---------------------------------------------------------------------------
// delay_jitter_packet_queue_top
// One-direction delay and jitter emulator on packet descriptors.
// ---------------------------------------------------------------------------
//  channel | ports                         | contents
//  --------+-------------------------------+-----------------------------------
//  request | in_tvalid/tready/tdata/tuser  | tuser: cmd; tdata: time, handle,
//          |                               | length, unreliable
//  result  | out_tvalid/tready/tdata/tuser | tuser: status; tlast: last of run;
//          | out_tlast                     | tdata: handle, length, flag, flushed
//  config  | cfg_we/addr/wdata             | delay, jitter span
//
// One request at a time. Pass-through, drop and close emit their result from the
// send or close state; a queued send steps through LCG multiply, jitter multiply,
// offset add and release clamp. A tick walks the queue head: each head read is a RAM
// access with registered data, up to 16 deliveries per tick.
// Reset clears pointers, count, generator and last release; no RAM clearing.
// A stalled result register holds the sequencer in its emitting state.
// ---------------------------------------------------------------------------
`include "delay_jitter_packet_queue_top_defines.svh"

module delay_jitter_packet_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [djpq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [djpq_pkg::CFG_W-1:0]         cfg_wdata,
  // requests
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] now_time, [47:32] packet_handle, [63:48] packet_length, [64] unreliable
  input  logic [djpq_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  logic [djpq_pkg::CMD_W-1:0]         in_tuser,
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] out_handle, [31:16] out_length, [32] out_unreliable, [37:33] flushed_count
  output logic [djpq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [2:0] status
  output logic [djpq_pkg::STATUS_W-1:0]      out_tuser,
  output logic                               out_tlast
);

  import djpq_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t st;
  logic     req_taken;
  logic     deliver_emit;

  djpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (ctl)
  );

  djpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (ctl),
    .st         (st)
  );

  // Accepted request with a valid command; unused codes leave the sequencer idle
  assign req_taken    = in_tvalid && in_tready &&
                        (in_tuser == CMD_SEND || in_tuser == CMD_TICK ||
                         in_tuser == CMD_CLOSE);
  assign deliver_emit = ctl.emit && (ctl.emit_status == STAT_DELIVERED);

  // Checks
  `DJPQ_ASSERT_NOW(a_emit_slot_free, ctl.emit, st.out_free, "result overwritten while stalled")
  `DJPQ_ASSERT_NOW(a_no_write_full, ctl.rel_step, !st.full, "entry written into full queue")
  `DJPQ_ASSERT_NEXT(a_one_at_a_time, req_taken, !in_tready, "request taken while busy")
  `DJPQ_ASSERT_NOW(a_deliver_needs_pend, deliver_emit, st.pend_valid, "delivery without held entry")

endmodule

// File: verif/delay_jitter_packet_queue_top_tb.sv
// ---------------------------------------------------------------------------
// delay_jitter_packet_queue_top_tb
// Self-checking bench for the packet delay/jitter queue. Requests (send, tick,
// close) are driven with random gaps while the result side stalls at random.
// A scoreboard class predicts release times from its own LCG and queue copy
// and checks every result field in order. Register settings run from zero to
// full scale, including saturating release times and negative offsets.
// ---------------------------------------------------------------------------
module delay_jitter_packet_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import djpq_pkg::*;

  localparam int QUEUE_SLOTS = 16;
  // command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // wait allowed for a request with no result
  localparam int SETTLE_CYCLES = 50;

  typedef struct {
    status_t       status;
    logic [15:0]   handle;
    logic [15:0]   length;
    logic          unrel;
    logic          is_last;
    logic [4:0]    flushed;
  } packet_result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: release schedule prediction and in-order result checking
  // -------------------------------------------------------------------------
  class delay_queue_scoreboard;
    logic [19:0]    delay_ticks;
    logic [19:0]    jitter_ticks;
    logic [31:0]    lcg_state;
    logic [31:0]    last_release;
    logic [31:0]    release_at [QUEUE_SLOTS];
    logic [32:0]    packet_desc [QUEUE_SLOTS];
    int unsigned    head;
    int unsigned    tail;
    int unsigned    occupancy;
    packet_result_t awaited_results [$];
    int             mismatches;

    function new();
      delay_ticks  = '0;
      jitter_ticks = '0;
      lcg_state    = RNG_SEED;
      last_release = '0;
      head         = 0;
      tail         = 0;
      occupancy    = 0;
      mismatches   = 0;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_IDX_DELAY) begin
        delay_ticks = value;
      end else begin
        jitter_ticks = value;
      end
    endfunction

    // Step the LCG; offset in whole ticks, rounded towards +inf
    function longint jitter_offset();
      longint frac;
      longint num;
      longint dly;
      longint jit;
      lcg_state = lcg_state * LCG_MUL + LCG_INC;
      frac = {40'd0, lcg_state[31:8]};
      dly  = {44'd0, delay_ticks};
      jit  = {44'd0, jitter_ticks};
      num  = dly * 16777216 + (2 * frac - 16777216) * jit;
      if (num >= 0) return (num + 33554431) / 33554432;
      return -((-num) / 33554432);
    endfunction

    function void append(status_t st, logic [32:0] desc, logic [4:0] flushed);
      packet_result_t r;
      r.status  = st;
      r.handle  = desc[15:0];
      r.length  = desc[31:16];
      r.unrel   = desc[32];
      r.is_last = 1'b0;
      r.flushed = flushed;
      awaited_results.push_back(r);
    endfunction

    // Work out the results of one accepted request
    function void note_request(logic [CMD_W-1:0] cmd, logic [31:0] now, logic [32:0] desc);
      longint at;
      longint prev;
      int     n;
      case (cmd)
        CMD_SEND: begin
          if (delay_ticks == 0 && jitter_ticks == 0 && occupancy == 0) begin
            append(STAT_PASSED, desc, '0);
          end else if (occupancy >= QUEUE_SLOTS) begin
            append(STAT_DROPPED, '0, '0);
          end else begin
            at   = longint'({32'd0, now}) + jitter_offset();
            prev = {32'd0, last_release};
            // keep order, then saturate at the top of the time range
            if (at < prev) begin
              at = prev;
            end
            if (at > 64'sh0000_0000_FFFF_FFFF) begin
              at = 64'sh0000_0000_FFFF_FFFF;
            end
            last_release      = at[31:0];
            release_at[tail]  = at[31:0];
            packet_desc[tail] = desc;
            tail              = (tail + 1) % QUEUE_SLOTS;
            occupancy++;
            append(STAT_QUEUED, '0, '0);
          end
        end
        CMD_TICK: begin
          n = 0;
          while (n < MAX_RESULTS && occupancy > 0 && release_at[head] <= now) begin
            append(STAT_DELIVERED, packet_desc[head], '0);
            head = (head + 1) % QUEUE_SLOTS;
            occupancy--;
            n++;
          end
          if (n == 0) begin
            append(STAT_NONE_DUE, '0, '0);
          end
        end
        CMD_CLOSE: begin
          append(STAT_FLUSHED, '0, occupancy[4:0]);
          head         = 0;
          tail         = 0;
          occupancy    = 0;
          last_release = '0;
        end
        default: return;
      endcase
      awaited_results[awaited_results.size() - 1].is_last = 1'b1;
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] data,
                               logic is_last);
      packet_result_t e;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d data %h last %0d", status, data, is_last);
        end
        return;
      end
      e = awaited_results.pop_front();
      if (status !== e.status || data[15:0] !== e.handle || data[31:16] !== e.length ||
          data[32] !== e.unrel || data[37:33] !== e.flushed || is_last !== e.is_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp st %0d h %h len %h u %0d fl %0d last %0d", e.status,
                   e.handle, e.length, e.unrel, e.flushed, e.is_last);
          $display("          got st %0d h %h len %h u %0d fl %0d last %0d", status,
                   data[15:0], data[31:16], data[32], data[37:33], is_last);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tlast;

  delay_queue_scoreboard sb;
  int                    sender_calm;
  int                    stall_left;
  int                    ready_calm;
  logic [31:0]           stim_now;

  delay_jitter_packet_queue_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("delay_jitter_packet_queue_top regression: fail");
    $finish;
  end

  // Result side back-pressure: mostly ready, short and long stalls, calm runs
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (ready_calm > 0) begin
      ready_calm--;
      out_tready = 1'b1;
    end else begin
      case ($urandom_range(0, 31))
        0: begin
          ready_calm = $urandom_range(20, 80);
          out_tready = 1'b1;
        end
        1: begin
          stall_left = $urandom_range(15, 40);
          out_tready = 1'b0;
        end
        2, 3, 4, 5, 6, 7, 8: begin
          stall_left = $urandom_range(0, 2);
          out_tready = 1'b0;
        end
        default: out_tready = 1'b1;
      endcase
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  // Present one request after a random gap; returns just after a falling edge
  task automatic drive_request(input logic [CMD_W-1:0] cmd, input logic [31:0] now,
                               input logic [15:0] handle, input logic [15:0] length,
                               input logic unrel);
    int gap;
    gap = 0;
    if (sender_calm > 0) begin
      sender_calm--;
    end else begin
      case ($urandom_range(0, 31))
        0:                      sender_calm = $urandom_range(10, 40);
        16, 17, 18, 19, 20, 21,
        22, 23, 24, 25, 26, 27,
        28:                     gap = $urandom_range(1, 3);
        29, 30, 31:             gap = $urandom_range(8, 30);
        default:                gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {7'd0, unrel, length, handle, now};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, now, {unrel, length, handle});
    @(negedge clk);
  endtask

  // Register update once every outstanding result has come back
  task automatic set_delay_jitter(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] jitter);
    in_tvalid = 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = CFG_IDX_DELAY;
    cfg_wdata = delay;
    sb.set_register(CFG_IDX_DELAY, delay);
    @(negedge clk);
    cfg_addr  = CFG_IDX_JITTER;
    cfg_wdata = jitter;
    sb.set_register(CFG_IDX_JITTER, jitter);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [CFG_W-1:0] phase_delay [7];
    logic [CFG_W-1:0] phase_jitter [7];
    logic [CMD_W-1:0] cmd;
    logic [31:0]      now;
    int               scale;
    int               accepted;
    int               pick;

    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_SEND;
    sender_calm = 0;
    stim_now    = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Zero registers, empty queue: straight pass-through and empty tick/close
    drive_request(CMD_SEND, 32'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    drive_request(CMD_SEND, 32'd5, 16'h0000, 16'h0000, 1'b0);
    drive_request(CMD_TICK, 32'd10, 16'h0, 16'h0, 1'b0);
    drive_request(CMD_CLOSE, 32'd11, 16'h0, 16'h0, 1'b0);
    drive_request(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);

    // Fill the queue, overflow it by one, then drain it in a single tick
    set_delay_jitter(20'd20, 20'd8);
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      drive_request(CMD_SEND, 32'd100 + i, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end
    drive_request(CMD_SEND, 32'd120, 16'h1234, 16'h5678, 1'b1);
    drive_request(CMD_TICK, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0);

    // Full-scale registers: release time saturates, later send is clamped
    set_delay_jitter(20'hFFFFF, 20'hFFFFF);
    drive_request(CMD_SEND, 32'hFFFF_FFF0, 16'hA5A5, 16'h5A5A, 1'b0);
    drive_request(CMD_TICK, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0);
    drive_request(CMD_SEND, 32'd0, 16'h0F0F, 16'hF0F0, 1'b1);
    drive_request(CMD_CLOSE, 32'd0, 16'h0, 16'h0, 1'b0);

    // Random phases over several register settings
    phase_delay  = '{20'd0, 20'd16, 20'd40, 20'd0, 20'hFFFFF, 20'd300, 20'd0};
    phase_jitter = '{20'd0, 20'd0, 20'd30, 20'd64, 20'hFFFFF, 20'hFFFFF, 20'd1};
    for (int p = 0; p < 7; p++) begin
      set_delay_jitter(phase_delay[p], phase_jitter[p]);
      scale    = (phase_delay[p] + phase_jitter[p]) / 16 + 2;
      accepted = 0;
      while (accepted < 43) begin
        // mostly advancing time, occasionally a wild timestamp
        if ($urandom_range(0, 99) < 5) begin
          now = $urandom();
        end else begin
          stim_now = stim_now + $urandom_range(0, scale);
          now      = stim_now;
        end
        pick = $urandom_range(0, 99);
        if (pick < 52) begin
          cmd = CMD_SEND;
        end else if (pick < 90) begin
          cmd = CMD_TICK;
        end else if (pick < 96) begin
          cmd = CMD_CLOSE;
        end else begin
          cmd = CMD_UNUSED;
        end
        drive_request(cmd, now, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        if (cmd != CMD_UNUSED) begin
          accepted++;
        end
      end
    end

    // Drain and settle
    in_tvalid = 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("delay_jitter_packet_queue_top regression: pass");
    end else begin
      $display("delay_jitter_packet_queue_top regression: fail");
    end
    $finish;
  end

endmodule
